// ===== rtl/fspo_pkg.sv =====
`default_nettype none
package fspo_pkg;

  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned DimW         = 7;
  localparam int unsigned CoordW       = 6;
  localparam int unsigned PixelW       = 24;

  // Configuration register indexes.
  localparam logic CfgWidthIdx  = 1'b0;
  localparam logic CfgHeightIdx = 1'b1;

  // Reciprocal of three in 11 fractional bits; exact floor for sums up to 765.
  localparam logic [10:0] ThirdRecip = 11'd683;

  typedef enum logic [2:0] {
    OP_FILL  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_INV   = 3'd3,
    OP_GRAY  = 3'd4,
    OP_VMIR  = 3'd5,
    OP_HMIR  = 3'd6,
    OP_NOP   = 3'd7
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [CoordW-1:0]  col;
    logic [CoordW-1:0]  row;
    logic [PixelW-1:0]  colour;
    logic               in_area;
  } cmd_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } dims_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       range_error;
  } resp_t;

endpackage
`default_nettype wire

// ===== rtl/frame_store_pixel_ops_engine_core.sv =====
// Steps to the result register: write ST_PWR, read ST_PRD and ST_PWAIT, then ST_RESP; fill
// writes each pixel, invert and grayscale read then write each, mirrors read a pair then write it.
// Throughput: one request at a time in the pixel sweep; the pixel memory has one read and
// one write port, and each invert, grayscale or swap step reads and writes in separate cycles.
// Reset: asynchronous active low; clears control and the size registers to 64 by 64.
// The pixel memory has no reset and holds undefined data until written.
`default_nettype none
module frame_store_pixel_ops_engine_core #(
  parameter int unsigned MaxWidth  = fspo_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = fspo_pkg::DefMaxHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Size registers: index 0 is image width, index 1 is image height.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[2:0], column[8:3], row[14:9], red_in[22:15], green_in[30:23],
  // blue_in[38:31], zero pad[39]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], range_error[24], zero pad[31:25]
  output logic [31:0]      m_axis_tdata
);

  // The front end decodes each request, checks its coordinate against the current
  // image size and queues it; the back end walks the pixel memory for that request.
  logic            push, full, q_valid, pop;
  fspo_pkg::cmd_t  cmd_in, cmd_q;
  fspo_pkg::dims_t dims;
  fspo_pkg::resp_t resp;

  fspo_front #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[38:0]),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (cmd_in),
    .dims_o     (dims)
  );

  // Short queue so the front end keeps taking requests while the back end sweeps.
  fspo_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (cmd_q)
  );

  fspo_back #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (cmd_q),
    .pop_o      (pop),
    .dims_i     (dims),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (resp)
  );

  assign m_axis_tdata = {7'd0, resp.range_error, resp.blue, resp.green, resp.red};

endmodule
`default_nettype wire

// ===== rtl/fspo_front.sv =====
`default_nettype none
module fspo_front #(
  parameter int unsigned MaxWidth  = fspo_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = fspo_pkg::DefMaxHeight
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_index_i,
  input  wire logic [fspo_pkg::DimW-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [38:0]              in_data_i,
  output logic                          push_o,
  input  wire logic                     full_i,
  output fspo_pkg::cmd_t                cmd_o,
  output fspo_pkg::dims_t               dims_o
);

  logic [fspo_pkg::DimW-1:0] width_q, height_q;
  logic [fspo_pkg::DimW-1:0] eff_w, eff_h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fspo_pkg::DimW'(64);
      height_q <= fspo_pkg::DimW'(64);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fspo_pkg::CfgWidthIdx) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  // A zero register acts as one; a value past the store size acts as the maximum.
  always_comb begin
    if (width_q == '0) begin
      eff_w = fspo_pkg::DimW'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      eff_w = fspo_pkg::DimW'(MaxWidth);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = fspo_pkg::DimW'(1);
    end else if (32'(height_q) > 32'(MaxHeight)) begin
      eff_h = fspo_pkg::DimW'(MaxHeight);
    end else begin
      eff_h = height_q;
    end
  end

  assign dims_o.width  = eff_w;
  assign dims_o.height = eff_h;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.op      = fspo_pkg::op_e'(in_data_i[2:0]);
    cmd_o.col     = in_data_i[8:3];
    cmd_o.row     = in_data_i[14:9];
    cmd_o.colour  = {in_data_i[22:15], in_data_i[30:23], in_data_i[38:31]};
    cmd_o.in_area = ({1'b0, in_data_i[8:3]} < eff_w) && ({1'b0, in_data_i[14:9]} < eff_h);
  end

endmodule
`default_nettype wire

// ===== rtl/fspo_cmd_fifo.sv =====
`default_nettype none
module fspo_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  fspo_pkg::cmd_t      data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output fspo_pkg::cmd_t      data_o
);

  localparam int unsigned PtrW = (fspo_pkg::QueueDepth > 1) ?
                                 $clog2(fspo_pkg::QueueDepth) : 1;

  fspo_pkg::cmd_t mem_q [fspo_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (32'(p) == fspo_pkg::QueueDepth - 1) begin
      next_ptr = '0;
    end else begin
      next_ptr = p + 1'b1;
    end
  endfunction

  assign full_o  = (32'(cnt_q) == fspo_pkg::QueueDepth);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fspo_back.sv =====
`default_nettype none
module fspo_back #(
  parameter int unsigned MaxWidth  = fspo_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = fspo_pkg::DefMaxHeight
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  fspo_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  fspo_pkg::dims_t     dims_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fspo_pkg::resp_t     out_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DW    = fspo_pkg::DimW;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_FILL   = 12'b0000_0000_0010,
    ST_PWR    = 12'b0000_0000_0100,
    ST_PRD    = 12'b0000_0000_1000,
    ST_PWAIT  = 12'b0000_0001_0000,
    ST_RMW_RD = 12'b0000_0010_0000,
    ST_RMW_WR = 12'b0000_0100_0000,
    ST_SW_RDA = 12'b0000_1000_0000,
    ST_SW_RDB = 12'b0001_0000_0000,
    ST_SW_WRA = 12'b0010_0000_0000,
    ST_SW_WRB = 12'b0100_0000_0000,
    ST_RESP   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [fspo_pkg::PixelW-1:0] mem [Depth];
  logic [fspo_pkg::PixelW-1:0] rdata_q, tmp_q, colour_q, res_q;
  fspo_pkg::op_e op_q;
  logic [DW-1:0] x_q, y_q, lim_x_q, lim_y_q;
  logic          err_q;
  logic          out_valid_q;
  fspo_pkg::resp_t out_q;

  logic [DW-1:0] px, py, lim_x, lim_y;
  logic [AddrW-1:0] addr_a, addr_b, waddr, raddr;
  logic [fspo_pkg::PixelW-1:0] wdata, new_px;
  logic we, last, advance;
  logic [9:0]  sum;
  logic [20:0] prod;
  logic [7:0]  gray;
  logic        load_out;

  // Pixel pair addresses: A is the sweep position, B its mirror partner.
  assign px     = (op_q == fspo_pkg::OP_HMIR) ? DW'(dims_i.width - 1'b1 - x_q) : x_q;
  assign py     = (op_q == fspo_pkg::OP_VMIR) ? DW'(dims_i.height - 1'b1 - y_q) : y_q;
  assign addr_a = AddrW'(32'(y_q) * 32'(MaxWidth) + 32'(x_q));
  assign addr_b = AddrW'(32'(py) * 32'(MaxWidth) + 32'(px));

  assign sum  = 10'(rdata_q[23:16]) + 10'(rdata_q[15:8]) + 10'(rdata_q[7:0]);
  assign prod = 21'(sum) * 21'(fspo_pkg::ThirdRecip);
  assign gray = prod[18:11];
  assign new_px = (op_q == fspo_pkg::OP_GRAY) ? {gray, gray, gray} : ~rdata_q;

  assign last = (x_q == DW'(lim_x_q - 1'b1)) && (y_q == DW'(lim_y_q - 1'b1));

  assign lim_x = (cmd_i.op == fspo_pkg::OP_HMIR) ? (dims_i.width >> 1) : dims_i.width;
  assign lim_y = (cmd_i.op == fspo_pkg::OP_VMIR) ? (dims_i.height >> 1) : dims_i.height;

  assign load_out = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);
  assign pop_o    = (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    we      = 1'b0;
    wdata   = colour_q;
    waddr   = addr_a;
    raddr   = addr_a;
    advance = 1'b0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op) inside
            fspo_pkg::OP_FILL:  state_d = ST_FILL;
            fspo_pkg::OP_WRITE: state_d = cmd_i.in_area ? ST_PWR : ST_RESP;
            fspo_pkg::OP_READ:  state_d = cmd_i.in_area ? ST_PRD : ST_RESP;
            fspo_pkg::OP_INV,
            fspo_pkg::OP_GRAY:  state_d = ST_RMW_RD;
            fspo_pkg::OP_VMIR,
            fspo_pkg::OP_HMIR:  state_d = (lim_x == '0 || lim_y == '0) ? ST_RESP : ST_SW_RDA;
            default:            state_d = ST_RESP;
          endcase
        end
      end
      ST_FILL: begin
        we      = 1'b1;
        advance = 1'b1;
        state_d = last ? ST_RESP : ST_FILL;
      end
      ST_PWR: begin
        we      = 1'b1;
        state_d = ST_RESP;
      end
      ST_PRD:   state_d = ST_PWAIT;
      ST_PWAIT: state_d = ST_RESP;
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: begin
        we      = 1'b1;
        wdata   = new_px;
        advance = 1'b1;
        state_d = last ? ST_RESP : ST_RMW_RD;
      end
      ST_SW_RDA: state_d = ST_SW_RDB;
      ST_SW_RDB: begin
        raddr   = addr_b;
        state_d = ST_SW_WRA;
      end
      ST_SW_WRA: begin
        we      = 1'b1;
        wdata   = rdata_q;
        state_d = ST_SW_WRB;
      end
      ST_SW_WRB: begin
        we      = 1'b1;
        waddr   = addr_b;
        wdata   = tmp_q;
        advance = 1'b1;
        state_d = last ? ST_RESP : ST_SW_RDA;
      end
      ST_RESP: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q     <= cmd_i.op;
      colour_q <= cmd_i.colour;
      lim_x_q  <= lim_x;
      lim_y_q  <= lim_y;
      res_q    <= '0;
      if (cmd_i.op == fspo_pkg::OP_WRITE || cmd_i.op == fspo_pkg::OP_READ) begin
        x_q   <= DW'(cmd_i.col);
        y_q   <= DW'(cmd_i.row);
        err_q <= !cmd_i.in_area;
      end else begin
        x_q   <= '0;
        y_q   <= '0;
        err_q <= 1'b0;
      end
    end else if (advance) begin
      if (x_q == DW'(lim_x_q - 1'b1)) begin
        x_q <= '0;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
    if (state_q == ST_SW_RDB) begin
      tmp_q <= rdata_q;
    end
    if (state_q == ST_PWAIT) begin
      res_q <= rdata_q;
    end
    if (load_out) begin
      out_q.red         <= res_q[23:16];
      out_q.green       <= res_q[15:8];
      out_q.blue        <= res_q[7:0];
      out_q.range_error <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;

  localparam int unsigned MaxW = 64;
  localparam int unsigned MaxH = 64;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       range_error;
  } pixel_ack_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  frame_store_pixel_ops_engine_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Shadow image and size registers used to predict each acknowledgement.
  logic [23:0] shadow_img [MaxW*MaxH];
  bit          shadow_written [MaxW*MaxH];
  logic [6:0]  shadow_width;
  logic [6:0]  shadow_height;

  logic [39:0] cmd_pending [$];
  pixel_ack_t  ack_expected [$];
  int unsigned ack_seen;
  int unsigned mismatches;
  int unsigned op_hits [8];
  bit          hold_sender;

  function automatic int unsigned eff_dim(logic [6:0] r, int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic int unsigned pix_at(int unsigned x, int unsigned y);
    return y * MaxW + x;
  endfunction

  // Applies one command to the shadow image and returns the predicted acknowledgement.
  function automatic pixel_ack_t apply_pixel_cmd(logic [39:0] word);
    fspo_pkg::op_e op;
    int unsigned cx, cy, w, h, a, b;
    logic [23:0] colour, t;
    logic [9:0]  sum;
    logic [7:0]  gray;
    pixel_ack_t  ack;
    op = fspo_pkg::op_e'(word[2:0]);
    cx = word[8:3];
    cy = word[14:9];
    colour = {word[22:15], word[30:23], word[38:31]};
    w = eff_dim(shadow_width, MaxW);
    h = eff_dim(shadow_height, MaxH);
    ack = '0;
    case (op)
      fspo_pkg::OP_FILL: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++) begin
            shadow_img[pix_at(x, y)] = colour;
            shadow_written[pix_at(x, y)] = 1'b1;
          end
      end
      fspo_pkg::OP_WRITE: begin
        if (cx < w && cy < h) begin
          shadow_img[pix_at(cx, cy)] = colour;
          shadow_written[pix_at(cx, cy)] = 1'b1;
        end else begin
          ack.range_error = 1'b1;
        end
      end
      fspo_pkg::OP_READ: begin
        if (cx < w && cy < h) {ack.red, ack.green, ack.blue} = shadow_img[pix_at(cx, cy)];
        else ack.range_error = 1'b1;
      end
      fspo_pkg::OP_INV: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            shadow_img[pix_at(x, y)] = ~shadow_img[pix_at(x, y)];
      end
      fspo_pkg::OP_GRAY: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++) begin
            t = shadow_img[pix_at(x, y)];
            sum = 10'(t[23:16]) + 10'(t[15:8]) + 10'(t[7:0]);
            gray = 8'(sum / 10'd3);
            shadow_img[pix_at(x, y)] = {gray, gray, gray};
          end
      end
      fspo_pkg::OP_VMIR: begin
        for (int x = 0; x < w; x++)
          for (int y = 0; y < h / 2; y++) begin
            a = pix_at(x, y);
            b = pix_at(x, h - 1 - y);
            t = shadow_img[a];
            shadow_img[a] = shadow_img[b];
            shadow_img[b] = t;
          end
      end
      fspo_pkg::OP_HMIR: begin
        for (int x = 0; x < w / 2; x++)
          for (int y = 0; y < h; y++) begin
            a = pix_at(x, y);
            b = pix_at(w - 1 - x, y);
            t = shadow_img[a];
            shadow_img[a] = shadow_img[b];
            shadow_img[b] = t;
          end
      end
      default: ;
    endcase
    return ack;
  endfunction

  // True when every pixel of the current area holds written data, so whole-image
  // commands never touch undefined pixels.
  function automatic bit area_written();
    for (int y = 0; y < eff_dim(shadow_height, MaxH); y++)
      for (int x = 0; x < eff_dim(shadow_width, MaxW); x++)
        if (!shadow_written[pix_at(x, y)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [39:0] pack_cmd(fspo_pkg::op_e op, int unsigned x,
                                           int unsigned y, logic [23:0] colour);
    return {1'b0, colour[7:0], colour[15:8], colour[23:16], y[5:0], x[5:0], op};
  endfunction

  // Driver: bursts of requests separated by random gaps. Prediction happens at the
  // accepting edge so the shadow image tracks the order the block sees.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ack_expected.push_back(apply_pixel_cmd(s_axis_tdata));
        op_hits[s_axis_tdata[2:0]]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_pending.size() != 0 && !hold_sender) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cmd_pending.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a slowly rotating pattern with stretches of full acceptance.
  int unsigned stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase   <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[7:6] == 2'd0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: compares each accepted acknowledgement with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_ack_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tdata[24]};
      ack_seen++;
      if (ack_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected acknowledgement %h", m_axis_tdata);
      end else begin
        want = ack_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ack %0d: expected r=%h g=%h b=%h err=%b, got r=%h g=%h b=%h err=%b",
                     ack_seen, want.red, want.green, want.blue, want.range_error,
                     got.red, got.green, got.blue, got.range_error);
        end
      end
    end
  end

  task automatic wait_idle();
    while (cmd_pending.size() != 0 || s_axis_tvalid || ack_expected.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_size(logic idx, logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == fspo_pkg::CfgWidthIdx) shadow_width = value;
    else shadow_height = value;
  endtask

  task automatic queue_cmd(fspo_pkg::op_e op, int unsigned x, int unsigned y,
                           logic [23:0] colour);
    cmd_pending.push_back(pack_cmd(op, x, y, colour));
  endtask

  function automatic logic [23:0] rand_colour();
    return 24'($urandom);
  endfunction

  // One random phase: start with a fill so whole-image commands see defined pixels,
  // then a mix of pixel accesses, transforms, out-of-range and unknown commands.
  task automatic random_phase(int unsigned count);
    int unsigned k;
    queue_cmd(fspo_pkg::OP_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
              rand_colour());
    for (int i = 1; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) queue_cmd(fspo_pkg::OP_WRITE, $urandom_range(0, 63),
                            $urandom_range(0, 63), rand_colour());
      else if (k < 65) queue_cmd(fspo_pkg::OP_READ, $urandom_range(0, 63),
                                 $urandom_range(0, 63), rand_colour());
      else if (k < 72) queue_cmd(fspo_pkg::OP_INV, $urandom_range(0, 63),
                                 $urandom_range(0, 63), rand_colour());
      else if (k < 79) queue_cmd(fspo_pkg::OP_GRAY, $urandom_range(0, 63),
                                 $urandom_range(0, 63), rand_colour());
      else if (k < 86) queue_cmd(fspo_pkg::OP_VMIR, $urandom_range(0, 63),
                                 $urandom_range(0, 63), rand_colour());
      else if (k < 93) queue_cmd(fspo_pkg::OP_HMIR, $urandom_range(0, 63),
                                 $urandom_range(0, 63), rand_colour());
      else if (k < 96) queue_cmd(fspo_pkg::OP_FILL, $urandom_range(0, 63),
                                 $urandom_range(0, 63), rand_colour());
      else queue_cmd(fspo_pkg::OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                     rand_colour());
    end
  endtask

  initial begin
    logic [6:0] sizes [6][2];
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i  = '0;
    hold_sender = 1'b0;
    shadow_width  = 7'd64;
    shadow_height = 7'd64;
    mismatches  = 0;
    ack_seen    = 0;
    foreach (shadow_img[i]) begin
      shadow_img[i] = '0;
      shadow_written[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tiny odd image, extremes of colour and coordinates.
    write_size(fspo_pkg::CfgWidthIdx, 7'd3);
    write_size(fspo_pkg::CfgHeightIdx, 7'd5);
    queue_cmd(fspo_pkg::OP_FILL, 0, 0, 24'hFFFFFF);
    queue_cmd(fspo_pkg::OP_WRITE, 0, 0, 24'h000000);
    queue_cmd(fspo_pkg::OP_WRITE, 2, 4, 24'hFF00FF);
    queue_cmd(fspo_pkg::OP_WRITE, 1, 2, 24'h12AB7F);
    queue_cmd(fspo_pkg::OP_WRITE, 3, 0, 24'hABCDEF);
    queue_cmd(fspo_pkg::OP_WRITE, 63, 63, 24'hFFFFFF);
    queue_cmd(fspo_pkg::OP_READ, 0, 5, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 2, 4, 24'h0);
    queue_cmd(fspo_pkg::OP_VMIR, 0, 0, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 2, 0, 24'h0);
    queue_cmd(fspo_pkg::OP_HMIR, 0, 0, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 0, 0, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 1, 2, 24'h0);
    queue_cmd(fspo_pkg::OP_INV, 0, 0, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 2, 4, 24'h0);
    queue_cmd(fspo_pkg::OP_GRAY, 0, 0, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 1, 2, 24'h0);
    queue_cmd(fspo_pkg::OP_READ, 0, 4, 24'h0);
    queue_cmd(fspo_pkg::OP_NOP, 63, 63, 24'hFFFFFF);
    queue_cmd(fspo_pkg::OP_READ, 0, 0, 24'h0);
    // Hold the sender until the block has answered everything so far.
    wait_idle();

    // Size settings, extremes among them; zero acts as one, above 64 acts as 64.
    sizes = '{'{7'd64, 7'd64}, '{7'd0, 7'd0}, '{7'd127, 7'd1}, '{7'd1, 7'd100},
              '{7'd7, 7'd4}, '{7'd16, 7'd9}};
    for (int p = 0; p < 6; p++) begin
      write_size(fspo_pkg::CfgWidthIdx, sizes[p][0]);
      write_size(fspo_pkg::CfgHeightIdx, sizes[p][1]);
      random_phase((p == 0) ? 10 : 22);
      if (p == 2) begin
        // Pause mid-phase until every result so far has come back.
        while (cmd_pending.size() > 11) @(posedge clk_i);
        hold_sender = 1'b1;
        while (s_axis_tvalid || ack_expected.size() != 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_idle();
    end

    $display("covered %0d acknowledgements: fill %0d, write %0d, read %0d, invert %0d,",
             ack_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("  grayscale %0d, mirrors %0d/%0d, unknown %0d, over seven size settings",
             op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
    if (mismatches == 0) begin
      $display("frame_store_pixel_ops_engine_core verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("frame_store_pixel_ops_engine_core verification failed");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("timeout");
    $display("frame_store_pixel_ops_engine_core verification failed");
    $finish;
  end

endmodule
